// File: rtl/ieic_pkg.sv
// Shared types and constants of the IR edge interval capture unit.
package ieic_pkg;

  typedef enum logic [2:0] {
    FUNC_EDGE   = 3'd0,
    FUNC_TICK   = 3'd1,
    FUNC_READ   = 3'd2,
    FUNC_FINISH = 3'd3,
    FUNC_START  = 3'd4
  } func_e;

  localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
  localparam logic [10:0] MIN_ENTRIES_RESET = 11'd7;
  localparam int unsigned PADDR_W           = 3;
  localparam logic [PADDR_W-1:0] ADDR_MIN_ENTRIES = 3'd0;

  typedef struct packed {
    logic accept;
    logic fill_step;
    logic read_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic fill_zero;
  } status_t;

endpackage

// File: rtl/ieic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ieic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ieic_ctrl.sv
// Controller state machine that sequences edge, fill, read and result steps.
module ieic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ieic_pkg::status_t status_i,
  output ieic_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (func_i == ieic_pkg::FUNC_EDGE && status_i.primed) begin
            state_d = ST_FILL;
          end else if (func_i == ieic_pkg::FUNC_READ) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_zero) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ieic_dp.sv
// Datapath with timer state, entry counter, interval store and result registers.
module ieic_dp #(
  parameter int unsigned CAPACITY = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ieic_pkg::cmd_t    cmd_i,
  output ieic_pkg::status_t status_o,
  input  logic [2:0]        func_i,
  input  logic [31:0]       timer_value_i,
  input  logic [10:0]       entry_index_i,
  input  logic [10:0]       min_entries_i,
  output logic [31:0]       read_value_o,
  output logic [10:0]       entry_count_o,
  output logic              capture_ok_o
);

  localparam int unsigned CW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CntMax = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] CntSat = CW'(CAPACITY - 2);

  logic [31:0]   last_q, last_d;
  logic [7:0]    ticks_q, ticks_d;
  logic          primed_q, primed_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    func_q, func_d;
  logic [10:0]   idx_q, idx_d;
  logic [31:0]   ival_q, ival_d;
  logic [7:0]    fill_q, fill_d;
  logic [31:0]   rv_q, rv_d;
  logic [10:0]   cnt_q, cnt_d;
  logic          ok_q, ok_d;

  logic          wrap;
  logic [31:0]   interval;
  logic [7:0]    fill_num;
  logic          we;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  logic          in_range;

  assign wrap     = (timer_value_i < last_q);
  assign interval = wrap ? ((ieic_pkg::ALL_ONES - last_q) + timer_value_i)
                         : (timer_value_i - last_q);
  assign fill_num = !wrap ? ticks_q : ((ticks_q == 8'd0) ? 8'd0 : ticks_q - 8'd1);
  assign in_range = (32'(idx_q) < 32'(CAPACITY));
  assign we       = cmd_i.fill_step;
  assign wdata    = (fill_q == 8'd0) ? ival_q : ieic_pkg::ALL_ONES;

  always_comb begin
    last_d   = last_q;
    ticks_d  = ticks_q;
    primed_d = primed_q;
    count_d  = count_q;
    func_d   = func_q;
    idx_d    = idx_q;
    ival_d   = ival_q;
    fill_d   = fill_q;
    rv_d     = rv_q;
    cnt_d    = cnt_q;
    ok_d     = ok_q;
    if (cmd_i.accept) begin
      func_d = func_i;
      idx_d  = entry_index_i;
      if (func_i == ieic_pkg::FUNC_EDGE) begin
        last_d   = timer_value_i;
        ticks_d  = 8'd0;
        ival_d   = interval;
        fill_d   = fill_num;
        primed_d = 1'b1;
      end else if (func_i == ieic_pkg::FUNC_TICK) begin
        ticks_d = ticks_q + 8'd1;
      end else if (func_i == ieic_pkg::FUNC_START) begin
        ticks_d = 8'd0;
      end
    end
    if (cmd_i.fill_step) begin
      if (fill_q != 8'd0) begin
        fill_d = fill_q - 8'd1;
      end
      if (count_q >= CntSat) begin
        count_d = CntMax;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.load_out) begin
      rv_d  = (func_q == ieic_pkg::FUNC_READ && in_range) ? rdata : 32'd0;
      cnt_d = 11'(count_q);
      ok_d  = (func_q == ieic_pkg::FUNC_FINISH) &&
              (32'(count_q) > 32'(min_entries_i)) && (count_q != CntMax);
      if (func_q == ieic_pkg::FUNC_FINISH) begin
        count_d  = '0;
        primed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      ticks_q  <= '0;
      primed_q <= 1'b0;
      count_q  <= '0;
    end else begin
      last_q   <= last_d;
      ticks_q  <= ticks_d;
      primed_q <= primed_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    idx_q  <= idx_d;
    ival_q <= ival_d;
    fill_q <= fill_d;
    rv_q   <= rv_d;
    cnt_q  <= cnt_d;
    ok_q   <= ok_d;
  end

  ieic_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.read_en),
    .raddr_i(CW'(idx_q)),
    .rdata_o(rdata)
  );

  assign status_o.primed    = primed_q;
  assign status_o.fill_zero = (fill_q == 8'd0);
  assign read_value_o       = rv_q;
  assign entry_count_o      = cnt_q;
  assign capture_ok_o       = ok_q;

endmodule

// File: rtl/ir_edge_interval_capture_unit.sv
// A plain item goes from IDLE to DONE, an entry read passes through READ first, and a
// primed edge passes through FILL, which writes F filler entries ahead of its interval.
// One item is handled at a time, its result loaded in DONE; the store takes one
// write per cycle through its single port, which sets the length of the fill run.
// Reset clears the controller, timer state, entry count and primed flag,
// and sets min_entries to 7; the interval store is not cleared.
module ir_edge_interval_capture_unit #(
  parameter int unsigned CAPACITY = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    func_i,
  input  logic [31:0]                   timer_value_i,
  input  logic [10:0]                   entry_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   read_value_o,
  output logic [10:0]                   entry_count_o,
  output logic                          capture_ok_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ieic_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [10:0]       min_entries_q, min_entries_d;
  ieic_pkg::cmd_t    cmd;
  ieic_pkg::status_t status;

  always_comb begin
    min_entries_d = min_entries_q;
    if (psel && penable && pwrite && paddr == ieic_pkg::ADDR_MIN_ENTRIES) begin
      min_entries_d = pwdata[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_entries_q <= ieic_pkg::MIN_ENTRIES_RESET;
    end else begin
      min_entries_q <= min_entries_d;
    end
  end

  assign prdata = (paddr == ieic_pkg::ADDR_MIN_ENTRIES) ? 32'(min_entries_q) : 32'd0;
  assign pready = 1'b1;

  ieic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ieic_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .timer_value_i(timer_value_i),
    .entry_index_i(entry_index_i),
    .min_entries_i(min_entries_q),
    .read_value_o (read_value_o),
    .entry_count_o(entry_count_o),
    .capture_ok_o (capture_ok_o)
  );

endmodule
